[rtl/feeq_pkg.sv]
// Shared types, codes and helpers for the fault edge event queue.
// Depends on nothing; used by feeq_ring, fault_edge_event_queue and the testbench.
`default_nettype none

package feeq_pkg;

  // Motor wheels per axle type. The bus source and the tracker count follow from it.
  localparam int unsigned WHEEL_COUNT = 4;
  localparam int unsigned TRK_DEPTH   = 2 * WHEEL_COUNT;
  localparam int unsigned TRK_AW      = $clog2(TRK_DEPTH);
  localparam int unsigned QUEUE_DEPTH = 16;

  localparam int unsigned SRC_W  = 4;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned DROP_W = 16;

  localparam logic [SRC_W-1:0]  SRC_BUS  = SRC_W'(2 * WHEEL_COUNT);
  localparam logic [DROP_W-1:0] DROP_MAX = '1;

  // Input item kinds.
  localparam logic [1:0] KIND_MOTOR = 2'd0;
  localparam logic [1:0] KIND_BUS   = 2'd1;
  localparam logic [1:0] KIND_DRAIN = 2'd2;

  // Bus states.
  localparam logic [1:0] BUS_OK      = 2'd0;
  localparam logic [1:0] BUS_WARNING = 2'd1;
  localparam logic [1:0] BUS_PASSIVE = 2'd2;
  localparam logic [1:0] BUS_OFF     = 2'd3;

  // Event kinds.
  localparam logic [2:0] EVT_ENTER    = 3'd0;
  localparam logic [2:0] EVT_CLEAR    = 3'd1;
  localparam logic [2:0] EVT_CHANGE   = 3'd2;
  localparam logic [2:0] EVT_SIG_OK   = 3'd3;
  localparam logic [2:0] EVT_SIG_LOST = 3'd4;

  // Configuration register indexes and reset values.
  localparam logic CFG_BUS_OFF     = 1'b0;
  localparam logic CFG_ERR_PASSIVE = 1'b1;
  localparam logic [CODE_W-1:0] BUS_OFF_RESET     = 8'd1;
  localparam logic [CODE_W-1:0] ERR_PASSIVE_RESET = 8'd2;

  typedef struct packed {
    logic [2:0]        kind;
    logic [SRC_W-1:0]  source;
    logic [CODE_W-1:0] fault_now;
    logic [CODE_W-1:0] fault_before;
    logic [7:0]        raw;
    logic [7:0]        esc;
    logic              enabled;
  } evt_t;

  typedef struct packed {
    logic [CODE_W-1:0] fault;
    logic              valid;
    logic              lost;
    logic              seen;
  } trk_t;

  typedef struct packed {
    logic draining;
    logic empty;
  } ring_stat_t;

  function automatic logic [2:0] fault_kind(input logic [CODE_W-1:0] before_code,
                                            input logic [CODE_W-1:0] now_code);
    logic [2:0] k;
    if (before_code == '0) begin
      k = EVT_ENTER;
    end else if (now_code == '0) begin
      k = EVT_CLEAR;
    end else begin
      k = EVT_CHANGE;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

[rtl/feeq_ring.sv]
// Ring of pending events in a single-port-write, registered-read memory,
// with overwrite-on-full, a saturating drop counter and the drain sequencer.
// Depends on feeq_pkg.
`default_nettype none

module feeq_ring #(
  parameter int unsigned QueueDepth = feeq_pkg::QUEUE_DEPTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire feeq_pkg::evt_t               push_evt_i,
  input  wire logic                         drain_i,
  output feeq_pkg::ring_stat_t              stat_o,
  output logic                              out_valid_o,
  output feeq_pkg::evt_t                    out_evt_o,
  output logic                              out_last_o,
  output logic [feeq_pkg::DROP_W-1:0]       dropped_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  feeq_pkg::evt_t event_mem [QueueDepth];

  logic [PtrW-1:0]             wp_q, rp_q;
  logic [CntW-1:0]             cnt_q;
  logic [feeq_pkg::DROP_W-1:0] drop_q;
  logic                        drain_q;
  logic                        rvalid_q, rlast_q;
  feeq_pkg::evt_t              rdata_q;
  logic                        full;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full = (cnt_q == CntW'(QueueDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      rp_q     <= '0;
      cnt_q    <= '0;
      drop_q   <= '0;
      drain_q  <= 1'b0;
      rvalid_q <= 1'b0;
      rlast_q  <= 1'b0;
    end else begin
      rvalid_q <= drain_q;
      rlast_q  <= drain_q && (cnt_q == CntW'(1));
      if (push_i) begin
        wp_q <= ptr_inc(wp_q);
        if (full) begin
          // The oldest event gives way to the new one.
          rp_q <= ptr_inc(rp_q);
          if (drop_q != feeq_pkg::DROP_MAX) begin
            drop_q <= drop_q + 1'b1;
          end
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (drain_i && (cnt_q != '0)) begin
        drain_q <= 1'b1;
      end
      // A drain walks the read pointer forward until it meets the write pointer.
      if (drain_q) begin
        rp_q  <= ptr_inc(rp_q);
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          drain_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      event_mem[wp_q] <= push_evt_i;
    end
    if (drain_q) begin
      rdata_q <= event_mem[rp_q];
    end
  end

  assign stat_o.draining = drain_q;
  assign stat_o.empty    = (cnt_q == '0);
  assign out_valid_o     = rvalid_q;
  assign out_evt_o       = rdata_q;
  assign out_last_o      = rlast_q;
  assign dropped_o       = drop_q;

endmodule

`default_nettype wire

[rtl/fault_edge_event_queue.sv]
// Fault edge event queue: motor trackers held in memory, the bus tracker, edge
// detection, and the event ring. Depends on feeq_pkg and feeq_ring.
// Timing: an item is taken when start_i is high and busy_o is low. A motor report
// reads its tracker from memory as it is taken, then compares and writes back; a bus
// report compares with its tracker register and updates it. A motor report queuing
// two events pushes them in turn, as the ring accepts one event a cycle. A drain walks
// out every pending event; the ring's single read port gives one event a cycle. Each
// event is shown for one cycle with out_valid_o; the receiver cannot stall the block.
`default_nettype none

module fault_edge_event_queue #(
  parameter int unsigned QueueDepth = feeq_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [7:0]                    cfg_wdata_i,
  input  wire logic [1:0]                    kind_i,
  input  wire logic                          steer_sel_i,
  input  wire logic [1:0]                    wheel_i,
  input  wire logic [7:0]                    motor_code_i,
  input  wire logic                          fb_valid_i,
  input  wire logic [7:0]                    vendor_code_i,
  input  wire logic [1:0]                    bus_state_i,
  input  wire logic [7:0]                    esc_id_i,
  input  wire logic                          drive_enabled_i,
  output logic                               out_valid_o,
  output logic [2:0]                         event_kind_o,
  output logic [3:0]                         source_o,
  output logic [7:0]                         fault_now_o,
  output logic [7:0]                         fault_before_o,
  output logic [7:0]                         event_raw_o,
  output logic [7:0]                         event_esc_o,
  output logic                               event_enabled_o,
  output logic [15:0]                        dropped_total_o,
  output logic                               last_o
);

  localparam int unsigned TrkAw = feeq_pkg::TRK_AW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_PUSH2 = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  // Captured item.
  logic [1:0]                        kind_q;
  logic [2:0]                        wheel_q;
  logic [feeq_pkg::SRC_W-1:0]        src_q;
  logic [7:0]                        code_q, raw_q, esc_q;
  logic                              hv_q, en_q;
  logic [1:0]                        bstate_q;
  logic [feeq_pkg::SRC_W-1:0]        src_in;

  // Configuration and bus tracker.
  logic [7:0] bus_off_q, err_passive_q;
  logic [7:0] bus_fault_q;
  logic       bus_seen_q;

  // Motor tracker memory, with a valid bit per entry so that reset reads as zero.
  feeq_pkg::trk_t                trk_mem [feeq_pkg::TRK_DEPTH];
  feeq_pkg::trk_t                trk_rdata_q;
  logic [feeq_pkg::TRK_DEPTH-1:0] trk_vld_q;
  feeq_pkg::trk_t                trk_cur, trk_new;
  logic                          trk_we;

  logic           sig_edge, flt_edge, in_range;
  feeq_pkg::evt_t sig_evt, flt_evt, bus_evt, evt2_q;
  logic [7:0]     bus_cur;
  logic           bus_push, bus_upd;

  logic                 ring_push, ring_drain;
  feeq_pkg::evt_t       ring_evt, out_evt;
  feeq_pkg::ring_stat_t ring_stat;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  assign src_in = steer_sel_i ? feeq_pkg::SRC_W'(wheel_i)
                              : feeq_pkg::SRC_W'(feeq_pkg::WHEEL_COUNT)
                                + feeq_pkg::SRC_W'(wheel_i);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q      <= kind_i;
      wheel_q     <= {1'b0, wheel_i};
      src_q       <= src_in;
      code_q      <= motor_code_i;
      raw_q       <= vendor_code_i;
      esc_q       <= esc_id_i;
      hv_q        <= fb_valid_i;
      en_q        <= drive_enabled_i;
      bstate_q    <= bus_state_i;
      trk_rdata_q <= trk_mem[src_in[TrkAw-1:0]];
    end
    if (trk_we) begin
      trk_mem[src_q[TrkAw-1:0]] <= trk_new;
    end
    if (state_q == S_EXEC) begin
      evt2_q <= flt_evt;
    end
  end

  // Tracker compare and update.
  assign in_range = (wheel_q < 3'(feeq_pkg::WHEEL_COUNT));
  assign trk_cur  = trk_vld_q[src_q[TrkAw-1:0]] ? trk_rdata_q : '0;
  assign sig_edge = (hv_q != trk_cur.valid) && (hv_q ? trk_cur.lost : trk_cur.seen);
  assign flt_edge = hv_q && trk_cur.seen && (code_q != trk_cur.fault)
                    && ((trk_cur.fault != '0) || (code_q != '0));

  always_comb begin
    trk_new.fault = hv_q ? code_q : trk_cur.fault;
    trk_new.valid = hv_q;
    trk_new.lost  = sig_edge ? !hv_q : trk_cur.lost;
    trk_new.seen  = 1'b1;
  end

  always_comb begin
    sig_evt.kind         = hv_q ? feeq_pkg::EVT_SIG_OK : feeq_pkg::EVT_SIG_LOST;
    sig_evt.source       = src_q;
    sig_evt.fault_now    = trk_cur.fault;
    sig_evt.fault_before = trk_cur.fault;
    sig_evt.raw          = raw_q;
    sig_evt.esc          = esc_q;
    sig_evt.enabled      = en_q;

    flt_evt.kind         = feeq_pkg::fault_kind(trk_cur.fault, code_q);
    flt_evt.source       = src_q;
    flt_evt.fault_now    = code_q;
    flt_evt.fault_before = trk_cur.fault;
    flt_evt.raw          = raw_q;
    flt_evt.esc          = esc_q;
    flt_evt.enabled      = en_q;
  end

  // Bus state mapped to a fault code through the configuration registers.
  always_comb begin
    case (bstate_q)
      feeq_pkg::BUS_OFF:     bus_cur = bus_off_q;
      feeq_pkg::BUS_PASSIVE: bus_cur = err_passive_q;
      default:               bus_cur = '0;
    endcase
    bus_evt.kind         = feeq_pkg::fault_kind(bus_fault_q, bus_cur);
    bus_evt.source       = feeq_pkg::SRC_BUS;
    bus_evt.fault_now    = bus_cur;
    bus_evt.fault_before = bus_fault_q;
    bus_evt.raw          = {6'd0, bstate_q};
    bus_evt.esc          = '0;
    bus_evt.enabled      = en_q;
  end
  assign bus_push = bus_seen_q && (bus_cur != bus_fault_q);

  always_comb begin
    state_d    = state_q;
    ring_push  = 1'b0;
    ring_evt   = sig_evt;
    ring_drain = 1'b0;
    trk_we     = 1'b0;
    bus_upd    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (kind_q)
          feeq_pkg::KIND_MOTOR: begin
            if (in_range) begin
              trk_we = 1'b1;
              if (sig_edge) begin
                ring_push = 1'b1;
                ring_evt  = sig_evt;
                if (flt_edge) begin
                  state_d = S_PUSH2;
                end
              end else if (flt_edge) begin
                ring_push = 1'b1;
                ring_evt  = flt_evt;
              end
            end
          end
          feeq_pkg::KIND_BUS: begin
            bus_upd   = 1'b1;
            ring_push = bus_push;
            ring_evt  = bus_evt;
          end
          feeq_pkg::KIND_DRAIN: begin
            ring_drain = 1'b1;
            state_d    = S_DRAIN;
          end
          default: ;
        endcase
      end
      S_PUSH2: begin
        ring_push = 1'b1;
        ring_evt  = evt2_q;
        state_d   = S_IDLE;
      end
      S_DRAIN: begin
        if (!ring_stat.draining) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      bus_off_q     <= feeq_pkg::BUS_OFF_RESET;
      err_passive_q <= feeq_pkg::ERR_PASSIVE_RESET;
      bus_fault_q   <= '0;
      bus_seen_q    <= 1'b0;
      trk_vld_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          feeq_pkg::CFG_BUS_OFF:     bus_off_q     <= cfg_wdata_i;
          feeq_pkg::CFG_ERR_PASSIVE: err_passive_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (bus_upd) begin
        bus_fault_q <= bus_cur;
        bus_seen_q  <= 1'b1;
      end
      if (trk_we) begin
        trk_vld_q[src_q[TrkAw-1:0]] <= 1'b1;
      end
    end
  end

  feeq_ring #(
    .QueueDepth (QueueDepth)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (ring_push),
    .push_evt_i  (ring_evt),
    .drain_i     (ring_drain),
    .stat_o      (ring_stat),
    .out_valid_o (out_valid_o),
    .out_evt_o   (out_evt),
    .out_last_o  (last_o),
    .dropped_o   (dropped_total_o)
  );

  assign event_kind_o    = out_evt.kind;
  assign source_o        = out_evt.source;
  assign fault_now_o     = out_evt.fault_now;
  assign fault_before_o  = out_evt.fault_before;
  assign event_raw_o     = out_evt.raw;
  assign event_esc_o     = out_evt.esc;
  assign event_enabled_o = out_evt.enabled;

  // The ring never takes a new event while a drain walks it.
  a_no_push_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_push |-> !ring_stat.draining)
    else $error("event pushed while the ring is draining");

  // The last beat of a drain is not followed by another beat.
  a_last_ends_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |=> !out_valid_o)
    else $error("beat after the last beat of a drain");

  // A drain of an empty ring produces nothing.
  a_empty_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ring_drain && ring_stat.empty) |=> !ring_stat.draining)
    else $error("empty drain started a walk");

  // A second event is only pushed straight after a motor report was evaluated.
  a_push2_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH2) |-> ($past(state_q) == S_EXEC))
    else $error("second push without a preceding evaluation");

endmodule

`default_nettype wire

[test/feeq_scoreboard_pkg.sv]
// Scoreboard for the fault edge event queue testbench: the report item type and
// a class that predicts queued events and checks every drained beat.
// Depends on feeq_pkg for widths, codes and the event layout.
`timescale 1ns / 1ps

package feeq_scoreboard_pkg;

  import feeq_pkg::*;

  // The fourth item kind, which the block is expected to ignore.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic              steer_sel;
    logic [1:0]        wheel;
    logic [CODE_W-1:0] motor_code;
    logic              fb_valid;
    logic [7:0]        vendor_code;
    logic [1:0]        bus_state;
    logic [7:0]        esc_id;
    logic              drive_enabled;
  } report_t;

  typedef struct packed {
    evt_t              ev;
    logic [DROP_W-1:0] dropped;
    logic              is_last;
  } drain_beat_t;

  class fault_event_scoreboard;
    trk_t              motor_trk[TRK_DEPTH];
    logic [CODE_W-1:0] bus_code;
    bit                bus_known;
    evt_t              ring[QUEUE_DEPTH];
    int unsigned       wr_ptr;
    int unsigned       rd_ptr;
    int unsigned       pending;
    logic [DROP_W-1:0] drops;
    logic [CODE_W-1:0] off_code;
    logic [CODE_W-1:0] passive_code;
    drain_beat_t       expected_events[$];
    int unsigned       errors;

    function new();
      foreach (motor_trk[i]) motor_trk[i] = '0;
      bus_code     = '0;
      bus_known    = 1'b0;
      wr_ptr       = 0;
      rd_ptr       = 0;
      pending      = 0;
      drops        = '0;
      off_code     = BUS_OFF_RESET;
      passive_code = ERR_PASSIVE_RESET;
      errors       = 0;
    endfunction

    function void set_code(logic idx, logic [CODE_W-1:0] value);
      if (idx == CFG_BUS_OFF) begin
        off_code = value;
      end else begin
        passive_code = value;
      end
    endfunction

    function logic [2:0] edge_kind(logic [CODE_W-1:0] was, logic [CODE_W-1:0] now_code);
      if (was == '0) return EVT_ENTER;
      if (now_code == '0) return EVT_CLEAR;
      return EVT_CHANGE;
    endfunction

    // A full ring loses its oldest entry to make room.
    function void add_event(evt_t e);
      if (pending >= QUEUE_DEPTH) begin
        rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
        if (drops != DROP_MAX) drops++;
      end else begin
        pending++;
      end
      ring[wr_ptr] = e;
      wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
    endfunction

    function void note_item(report_t it);
      evt_t              e;
      int unsigned       src;
      bit                sig_edge;
      bit                flt_edge;
      logic [CODE_W-1:0] cur;
      drain_beat_t       b;
      e = '0;
      case (it.kind)
        KIND_MOTOR: begin
          if (it.wheel < WHEEL_COUNT) begin
            src = it.steer_sel ? it.wheel : WHEEL_COUNT + it.wheel;
            sig_edge = (it.fb_valid != motor_trk[src].valid) &&
                       (it.fb_valid ? motor_trk[src].lost : motor_trk[src].seen);
            flt_edge = it.fb_valid && motor_trk[src].seen &&
                       (it.motor_code != motor_trk[src].fault);
            e.source  = SRC_W'(src);
            e.raw     = it.vendor_code;
            e.esc     = it.esc_id;
            e.enabled = it.drive_enabled;
            if (sig_edge) begin
              motor_trk[src].lost = !it.fb_valid;
              e.kind         = it.fb_valid ? EVT_SIG_OK : EVT_SIG_LOST;
              e.fault_now    = motor_trk[src].fault;
              e.fault_before = motor_trk[src].fault;
              add_event(e);
            end
            if (flt_edge) begin
              e.kind         = edge_kind(motor_trk[src].fault, it.motor_code);
              e.fault_now    = it.motor_code;
              e.fault_before = motor_trk[src].fault;
              add_event(e);
            end
            motor_trk[src].valid = it.fb_valid;
            motor_trk[src].seen  = 1'b1;
            if (it.fb_valid) motor_trk[src].fault = it.motor_code;
          end
        end
        KIND_BUS: begin
          if (it.bus_state == BUS_OFF) begin
            cur = off_code;
          end else if (it.bus_state == BUS_PASSIVE) begin
            cur = passive_code;
          end else begin
            cur = '0;
          end
          // The first bus report only sets the baseline.
          if (bus_known && cur != bus_code) begin
            e.kind         = edge_kind(bus_code, cur);
            e.source       = SRC_BUS;
            e.fault_now    = cur;
            e.fault_before = bus_code;
            e.raw          = 8'(it.bus_state);
            e.esc          = '0;
            e.enabled      = it.drive_enabled;
            add_event(e);
          end
          bus_code  = cur;
          bus_known = 1'b1;
        end
        KIND_DRAIN: begin
          for (int unsigned i = 0; i < pending; i++) begin
            b.ev      = ring[(rd_ptr + i) % QUEUE_DEPTH];
            b.dropped = drops;
            b.is_last = (i + 1 == pending);
            expected_events.insert(expected_events.size(), b);
          end
          rd_ptr  = wr_ptr;
          pending = 0;
        end
        default: ;
      endcase
    endfunction

    function string describe(drain_beat_t b);
      return $sformatf({"kind=%0d src=%0d now=%02h before=%02h raw=%02h esc=%02h",
                        " en=%0d drop=%0d last=%0d"},
                       b.ev.kind, b.ev.source, b.ev.fault_now, b.ev.fault_before, b.ev.raw,
                       b.ev.esc, b.ev.enabled, b.dropped, b.is_last);
    endfunction

    function void check_event(drain_beat_t got);
      drain_beat_t want;
      if (expected_events.size() == 0) begin
        errors++;
        if (errors <= 10) $display("event beat with none expected: %s", describe(got));
      end else begin
        want = expected_events.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("event beat mismatch\n  expected %s\n  actual   %s",
                     describe(want), describe(got));
          end
        end
      end
    endfunction
  endclass

endpackage

[test/tb_fault_edge_event_queue.sv]
// Testbench for fault_edge_event_queue: directed and random reports and drains,
// with drained events checked against a scoreboard. Depends on feeq_pkg,
// feeq_scoreboard_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_fault_edge_event_queue;

  import feeq_pkg::*;
  import feeq_scoreboard_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 70;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned FLOOD_PAIRS     = 8;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        start_i         = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic        cfg_index_i     = CFG_BUS_OFF;
  logic [7:0]  cfg_wdata_i     = '0;
  logic [1:0]  kind_i          = KIND_MOTOR;
  logic        steer_sel_i     = 1'b0;
  logic [1:0]  wheel_i         = '0;
  logic [7:0]  motor_code_i    = '0;
  logic        fb_valid_i      = 1'b0;
  logic [7:0]  vendor_code_i   = '0;
  logic [1:0]  bus_state_i     = BUS_OK;
  logic [7:0]  esc_id_i        = '0;
  logic        drive_enabled_i = 1'b0;
  logic        busy_o;
  logic        out_valid_o;
  logic [2:0]  event_kind_o;
  logic [3:0]  source_o;
  logic [7:0]  fault_now_o;
  logic [7:0]  fault_before_o;
  logic [7:0]  event_raw_o;
  logic [7:0]  event_esc_o;
  logic        event_enabled_o;
  logic [15:0] dropped_total_o;
  logic        last_o;

  fault_event_scoreboard sb = new();
  drain_beat_t           seen_beat;
  int unsigned           stall_cycles = 0;

  fault_edge_event_queue uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .kind_i         (kind_i),
    .steer_sel_i    (steer_sel_i),
    .wheel_i        (wheel_i),
    .motor_code_i   (motor_code_i),
    .fb_valid_i     (fb_valid_i),
    .vendor_code_i  (vendor_code_i),
    .bus_state_i    (bus_state_i),
    .esc_id_i       (esc_id_i),
    .drive_enabled_i(drive_enabled_i),
    .out_valid_o    (out_valid_o),
    .event_kind_o   (event_kind_o),
    .source_o       (source_o),
    .fault_now_o    (fault_now_o),
    .fault_before_o (fault_before_o),
    .event_raw_o    (event_raw_o),
    .event_esc_o    (event_esc_o),
    .event_enabled_o(event_enabled_o),
    .dropped_total_o(dropped_total_o),
    .last_o         (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Every event beat is taken at the edge that ends its strobe cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      seen_beat.ev.kind         = event_kind_o;
      seen_beat.ev.source       = source_o;
      seen_beat.ev.fault_now    = fault_now_o;
      seen_beat.ev.fault_before = fault_before_o;
      seen_beat.ev.raw          = event_raw_o;
      seen_beat.ev.esc          = event_esc_o;
      seen_beat.ev.enabled      = event_enabled_o;
      seen_beat.dropped         = dropped_total_o;
      seen_beat.is_last         = last_o;
      sb.check_event(seen_beat);
    end
    if ((start_i && busy_o === 1'b0) || out_valid_o === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("fault_edge_event_queue test failed");
    $finish;
  end

  function automatic report_t motor_item(logic steer, logic [1:0] wheel, logic [7:0] code,
                                         logic hv, logic [7:0] raw, logic [7:0] esc,
                                         logic en);
    report_t it;
    it               = '0;
    it.kind          = KIND_MOTOR;
    it.steer_sel     = steer;
    it.wheel         = wheel;
    it.motor_code    = code;
    it.fb_valid      = hv;
    it.vendor_code   = raw;
    it.esc_id        = esc;
    it.drive_enabled = en;
    return it;
  endfunction

  function automatic report_t bus_item(logic [1:0] state, logic en);
    report_t it;
    it               = '0;
    it.kind          = KIND_BUS;
    it.bus_state     = state;
    it.drive_enabled = en;
    return it;
  endfunction

  function automatic report_t bare_item(logic [1:0] kind);
    report_t it;
    it      = '0;
    it.kind = kind;
    return it;
  endfunction

  // Small codes are favoured so that a tracker often sees the same code again.
  function automatic report_t random_item(int unsigned drain_pct);
    report_t     it;
    int unsigned pick;
    it.steer_sel     = 1'($urandom);
    it.wheel         = 2'($urandom);
    it.vendor_code   = 8'($urandom);
    it.bus_state     = 2'($urandom);
    it.esc_id        = 8'($urandom);
    it.drive_enabled = 1'($urandom);
    it.fb_valid      = ($urandom_range(3) != 0);
    case ($urandom_range(9))
      0, 1, 2: it.motor_code = '0;
      3, 4, 5: it.motor_code = 8'($urandom_range(3, 1));
      default: it.motor_code = 8'($urandom_range(255));
    endcase
    pick = $urandom_range(99);
    if (pick < drain_pct) begin
      it.kind = KIND_DRAIN;
    end else if (pick < drain_pct + 3) begin
      it.kind = KIND_UNUSED;
    end else if (pick < drain_pct + 25) begin
      it.kind = KIND_BUS;
    end else begin
      it.kind = KIND_MOTOR;
    end
    return it;
  endfunction

  // Holds the item on the ports until the block takes it; start stays high on return.
  task automatic send(input report_t it);
    @(negedge clk_i);
    kind_i          = it.kind;
    steer_sel_i     = it.steer_sel;
    wheel_i         = it.wheel;
    motor_code_i    = it.motor_code;
    fb_valid_i      = it.fb_valid;
    vendor_code_i   = it.vendor_code;
    bus_state_i     = it.bus_state;
    esc_id_i        = it.esc_id;
    drive_enabled_i = it.drive_enabled;
    start_i         = 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_item(it);
  endtask

  task automatic pause_sender(input int unsigned pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk_i);
      start_i = 1'b0;
    end
  endtask

  // Waits for the last expected beat, then lets any report still in flight finish.
  task automatic settle();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.expected_events.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_code(input logic idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_code(idx, value);
  endtask

  task automatic run_random(input int unsigned idle_pct, input int unsigned drain_pct);
    repeat (ITEMS_PER_PHASE) begin
      pause_sender(idle_pct);
      send(random_item(drain_pct));
    end
  endtask

  // Each pair loses and regains the signal with a new code: three events.
  task automatic flood(input int unsigned pairs);
    for (int unsigned k = 0; k < pairs; k++) begin
      send(motor_item(1'b0, 2'd3, 8'h00, 1'b0, 8'($urandom), 8'($urandom), 1'($urandom)));
      send(motor_item(1'b0, 2'd3, k[0] ? 8'hA5 : 8'h5A, 1'b1, 8'($urandom), 8'($urandom),
                      1'($urandom)));
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values of the bus codes are in force here.
    send(bare_item(KIND_DRAIN));
    send(bare_item(KIND_UNUSED));
    send(bus_item(BUS_OFF, 1'b1));
    send(bus_item(BUS_PASSIVE, 1'b0));
    send(bus_item(BUS_OK, 1'b1));
    send(bus_item(BUS_WARNING, 1'b0));
    send(bus_item(BUS_OFF, 1'b1));
    send(motor_item(1'b1, 2'd0, 8'h80, 1'b1, 8'hFF, 8'h00, 1'b1));
    send(motor_item(1'b1, 2'd0, 8'h00, 1'b0, 8'h12, 8'h34, 1'b0));
    send(motor_item(1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0));
    send(motor_item(1'b1, 2'd0, 8'h00, 1'b1, 8'h56, 8'h78, 1'b1));
    send(motor_item(1'b0, 2'd3, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0));
    send(motor_item(1'b0, 2'd3, 8'hFF, 1'b1, 8'h00, 8'hFF, 1'b0));
    send(motor_item(1'b0, 2'd3, 8'h01, 1'b1, 8'hAA, 8'h55, 1'b1));
    send(motor_item(1'b0, 2'd3, 8'h01, 1'b1, 8'h55, 8'hAA, 1'b1));
    send(bare_item(KIND_DRAIN));

    // A zero code makes bus-off count as healthy.
    settle();
    write_code(CFG_BUS_OFF, 8'd0);
    write_code(CFG_ERR_PASSIVE, 8'd255);
    send(bus_item(BUS_OFF, 1'b0));
    send(bus_item(BUS_PASSIVE, 1'b1));
    send(bus_item(BUS_OFF, 1'b1));
    send(motor_item(1'b1, 2'd3, 8'h42, 1'b1, 8'h0F, 8'hF0, 1'b1));
    send(bare_item(KIND_DRAIN));

    settle();
    write_code(CFG_BUS_OFF, 8'd255);
    write_code(CFG_ERR_PASSIVE, 8'd1);
    run_random(14, 17);

    settle();
    write_code(CFG_BUS_OFF, 8'($urandom_range(255, 1)));
    write_code(CFG_ERR_PASSIVE, 8'($urandom_range(255, 1)));
    run_random(76, 5);

    settle();
    write_code(CFG_BUS_OFF, 8'($urandom_range(255)));
    write_code(CFG_ERR_PASSIVE, 8'($urandom_range(255, 1)));
    run_random(0, 12);

    // Overrun the ring so that the oldest events are dropped, twice over.
    flood(FLOOD_PAIRS);
    send(bare_item(KIND_DRAIN));
    flood(12);
    send(bare_item(KIND_DRAIN));

    settle();
    repeat (10) @(negedge clk_i);
    if (sb.errors == 0 && sb.expected_events.size() == 0) begin
      $display("fault_edge_event_queue test passed");
    end else begin
      $display("fault_edge_event_queue test failed");
    end
    $finish;
  end

endmodule
